### sv/mbss_pkg.sv
`timescale 1ns / 1ps
// mbss_pkg: shared types, constants and the masked compare for the signature scan
// used by mbss_match and masked_byte_signature_scan_top; no dependencies
package mbss_pkg;

    localparam int MAX_SIG_BYTES = 8;
    localparam int NUM_SIGS      = 2;
    localparam int BYTE_W        = 8;
    localparam int ADDR_W        = 64;
    localparam int LEN_W         = 4;
    localparam int BYTE_IDX_W    = $clog2(MAX_SIG_BYTES);
    localparam int SIG_IDX_W     = 1;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG0_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG0_CARE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG0_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG1_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG1_CARE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG1_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 3'd6;

    typedef logic [MAX_SIG_BYTES-1:0][BYTE_W-1:0] recent_t;

    typedef struct packed {
        logic [MAX_SIG_BYTES*BYTE_W-1:0] sig_bytes;
        logic [MAX_SIG_BYTES-1:0]        care;
        logic [LEN_W-1:0]                length;
    } sig_cfg_t;

    // length clamped to the window size
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] length);
        logic [LEN_W-1:0] len;
        len = length;
        if (length > LEN_W'(MAX_SIG_BYTES))
        begin
            len = LEN_W'(MAX_SIG_BYTES);
        end
        return len;
    endfunction

    // recent[0] is the newest byte; signature byte j lines up with recent[len-1-j]
    function automatic logic sig_match(
        input recent_t           recent,
        input sig_cfg_t          cfg,
        input logic [ADDR_W-1:0] count
    );
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] idx;
        logic             hit;
        len = sat_len(cfg.length);
        hit = (len != '0) && (count >= ADDR_W'(len));
        for (int j = 0; j < MAX_SIG_BYTES; j++)
        begin
            idx = len - LEN_W'(1) - LEN_W'(j);
            if ((LEN_W'(j) < len) && cfg.care[j] &&
                (recent[idx[BYTE_IDX_W-1:0]] != cfg.sig_bytes[BYTE_W*j +: BYTE_W]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

### sv/masked_byte_signature_scan_top.sv
`timescale 1ns / 1ps
// masked_byte_signature_scan_top: byte stream scan for two masked signatures
// holds the configuration registers, byte window, count and result buffer
// uses mbss_pkg and mbss_match
//
// usage:
//   s_axis carries one memory byte per transaction in tdata[7:0]; tuser set marks
//   the first byte of a new region and restarts the byte count.
//   m_axis carries one hit per transaction: tdata is the start address of the
//   match (region base plus offset, wrapping), tuser the signature index, tlast
//   marks the last hit caused by one byte. hits of one byte come in index order.
//   cfg writes one register per transaction (index 0..6, others ignored) and is
//   always ready; write only while no byte is in flight.
//   a hit moves through input register, compare register and result buffer.
//   throughput: one byte per cycle while m_axis takes every hit and each byte
//   gives at most one hit; a byte that hits both signatures holds the result
//   buffer until both hits are taken.
//   when m_axis stalls the three stages fill and then s_axis tready drops.
//   reset clears configuration, window, byte count and all valid flags.
module masked_byte_signature_scan_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // mem_byte
    input  logic                                s_axis_tuser,   // region_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mbss_pkg::ADDR_W-1:0]         m_axis_tdata,   // hit_address
    output logic [mbss_pkg::SIG_IDX_W-1:0]      m_axis_tuser,   // sig_index
    output logic                                m_axis_tlast,   // run_end
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbss_pkg::ADDR_W-1:0]         cfg_data
);

    mbss_pkg::sig_cfg_t [mbss_pkg::NUM_SIGS-1:0]            sig_cfg_reg;
    logic [mbss_pkg::ADDR_W-1:0]                            region_base_reg;

    logic [mbss_pkg::MAX_SIG_BYTES-2:0][mbss_pkg::BYTE_W-1:0] window_reg;
    logic [mbss_pkg::ADDR_W-1:0]                            bytes_seen_reg;
    logic [mbss_pkg::ADDR_W-1:0]                            bytes_seen_next;

    logic                                                   s1_valid_reg;
    mbss_pkg::recent_t                                      s1_recent_reg;
    logic [mbss_pkg::ADDR_W-1:0]                            s1_count_reg;

    logic                                                   s2_valid;
    logic [mbss_pkg::NUM_SIGS-1:0]                          s2_hit;
    logic [mbss_pkg::NUM_SIGS-1:0][mbss_pkg::ADDR_W-1:0]    s2_offset;

    logic [mbss_pkg::NUM_SIGS-1:0]                          pend_valid_reg;
    logic [mbss_pkg::NUM_SIGS-1:0][mbss_pkg::ADDR_W-1:0]    pend_addr_reg;

    logic                                                   s_fire;
    logic                                                   m_fire;
    logic                                                   pend_free;
    logic                                                   pend_load;
    logic                                                   s2_en;
    logic                                                   s1_en;
    logic [mbss_pkg::SIG_IDX_W-1:0]                         sel;

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_cfg_reg     <= '0;
            region_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbss_pkg::CFG_SIG0_BYTES:  sig_cfg_reg[0].sig_bytes <= cfg_data;
                mbss_pkg::CFG_SIG0_CARE:   sig_cfg_reg[0].care      <= cfg_data[7:0];
                mbss_pkg::CFG_SIG0_LENGTH: sig_cfg_reg[0].length    <= cfg_data[3:0];
                mbss_pkg::CFG_SIG1_BYTES:  sig_cfg_reg[1].sig_bytes <= cfg_data;
                mbss_pkg::CFG_SIG1_CARE:   sig_cfg_reg[1].care      <= cfg_data[7:0];
                mbss_pkg::CFG_SIG1_LENGTH: sig_cfg_reg[1].length    <= cfg_data[3:0];
                mbss_pkg::CFG_REGION_BASE: region_base_reg          <= cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign m_fire    = m_axis_tvalid && m_axis_tready;
    assign pend_free = (pend_valid_reg == '0) || (($countones(pend_valid_reg) == 1) && m_fire);
    assign pend_load = s2_valid && pend_free;
    assign s2_en     = !s2_valid || pend_free;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign s_axis_tready = s1_en;

    // byte count, restarted at one at region start, saturating
    always_comb
    begin
        if (s_axis_tuser)
        begin
            bytes_seen_next = mbss_pkg::ADDR_W'(1);
        end
        else if (bytes_seen_reg == '1)
        begin
            bytes_seen_next = bytes_seen_reg;
        end
        else
        begin
            bytes_seen_next = bytes_seen_reg + mbss_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            bytes_seen_reg <= '0;
        end
        else if (s_fire)
        begin
            window_reg     <= {window_reg[mbss_pkg::MAX_SIG_BYTES-3:0], s_axis_tdata};
            bytes_seen_reg <= bytes_seen_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_recent_reg <= {window_reg, s_axis_tdata};
            s1_count_reg  <= bytes_seen_next;
        end
    end

    mbss_match u_match (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (s2_en),
        .item_valid      (s1_valid_reg),
        .recent          (s1_recent_reg),
        .count           (s1_count_reg),
        .sig_cfg         (sig_cfg_reg),
        .match_valid_reg (s2_valid),
        .hit_reg         (s2_hit),
        .offset_reg      (s2_offset)
    );

    // result buffer, one entry per signature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= '0;
        end
        else if (pend_load)
        begin
            pend_valid_reg <= s2_hit;
        end
        else if (m_fire)
        begin
            pend_valid_reg[sel] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            for (int k = 0; k < mbss_pkg::NUM_SIGS; k++)
            begin
                pend_addr_reg[k] <= region_base_reg + s2_offset[k];
            end
        end
    end

    // lowest pending index goes first
    always_comb
    begin
        sel = '0;
        for (int k = mbss_pkg::NUM_SIGS - 1; k >= 0; k--)
        begin
            if (pend_valid_reg[k])
            begin
                sel = mbss_pkg::SIG_IDX_W'(k);
            end
        end
    end

    assign m_axis_tvalid = |pend_valid_reg;
    assign m_axis_tdata  = pend_addr_reg[sel];
    assign m_axis_tuser  = sel;
    assign m_axis_tlast  = ($countones(pend_valid_reg) == 1);

    // two pending hits: the first taken leaves only the higher index
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg == '1) && m_fire |=> (pend_valid_reg == 2'b10))
        else $error("second hit lost or repeated");

    // a hit that is not the last of its byte is always signature 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_fire && !m_axis_tlast |-> (m_axis_tuser == '0))
        else $error("hits of one byte out of index order");

    // every accepted byte leaves a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (bytes_seen_reg != '0))
        else $error("byte count zero after a byte");

    // the buffer is never overwritten while a hit it holds is still owed
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_load |-> (pend_valid_reg == '0) || (m_fire && m_axis_tlast))
        else $error("result buffer overwritten");

endmodule

### sv/mbss_match.sv
`timescale 1ns / 1ps
// mbss_match: masked compare of the byte window against every signature
// registers hit flags and region offsets of the match starts; uses mbss_pkg
module mbss_match (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic                                           item_valid,
    input  mbss_pkg::recent_t                              recent,
    input  logic [mbss_pkg::ADDR_W-1:0]                    count,
    input  mbss_pkg::sig_cfg_t [mbss_pkg::NUM_SIGS-1:0]    sig_cfg,
    output logic                                           match_valid_reg,
    output logic [mbss_pkg::NUM_SIGS-1:0]                  hit_reg,
    output logic [mbss_pkg::NUM_SIGS-1:0][mbss_pkg::ADDR_W-1:0] offset_reg
);

    logic [mbss_pkg::NUM_SIGS-1:0]                       hit_next;
    logic [mbss_pkg::NUM_SIGS-1:0][mbss_pkg::ADDR_W-1:0] offset_next;

    always_comb
    begin
        for (int k = 0; k < mbss_pkg::NUM_SIGS; k++)
        begin
            hit_next[k]    = mbss_pkg::sig_match(recent, sig_cfg[k], count);
            offset_next[k] = count - mbss_pkg::ADDR_W'(mbss_pkg::sat_len(sig_cfg[k].length));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            match_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && item_valid)
        begin
            hit_reg    <= hit_next;
            offset_reg <= offset_next;
        end
    end

endmodule

### tb/mbss_hit_checker.sv
`timescale 1ns / 1ps
// mbss_hit_checker: watches the cfg, s_axis and m_axis channels, predicts the hits of every
// accepted byte and compares each m_axis transaction against the oldest expected hit
// uses mbss_pkg
module mbss_hit_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [mbss_pkg::ADDR_W-1:0]        m_axis_tdata,
    input  logic [mbss_pkg::SIG_IDX_W-1:0]     m_axis_tuser,
    input  logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbss_pkg::ADDR_W-1:0]        cfg_data,
    output int                                 mismatches,
    output int                                 hits_pending
);

    typedef struct packed {
        logic [mbss_pkg::ADDR_W-1:0]    addr;
        logic [mbss_pkg::SIG_IDX_W-1:0] sig;
        logic                           last;
    } hit_t;

    logic [mbss_pkg::MAX_SIG_BYTES*mbss_pkg::BYTE_W-1:0] sig_pat [mbss_pkg::NUM_SIGS];
    logic [mbss_pkg::MAX_SIG_BYTES-1:0]                  sig_mask [mbss_pkg::NUM_SIGS];
    logic [mbss_pkg::LEN_W-1:0]                          sig_size [mbss_pkg::NUM_SIGS];
    logic [mbss_pkg::ADDR_W-1:0]                         base_addr;
    logic [mbss_pkg::BYTE_W-1:0]                         history [mbss_pkg::MAX_SIG_BYTES-1];
    logic [mbss_pkg::ADDR_W-1:0]                         region_count;
    hit_t                                                expected_hits [$];
    int                                                  hits_seen;

    initial
    begin
        mismatches   = 0;
        hits_pending = 0;
        hits_seen    = 0;
    end

    task automatic report(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic apply_write(input logic [mbss_pkg::CFG_IDX_W-1:0] idx,
                               input logic [mbss_pkg::ADDR_W-1:0] data);
        case (idx)
            mbss_pkg::CFG_SIG0_BYTES:  sig_pat[0]  = data;
            mbss_pkg::CFG_SIG0_CARE:   sig_mask[0] = data[mbss_pkg::MAX_SIG_BYTES-1:0];
            mbss_pkg::CFG_SIG0_LENGTH: sig_size[0] = data[mbss_pkg::LEN_W-1:0];
            mbss_pkg::CFG_SIG1_BYTES:  sig_pat[1]  = data;
            mbss_pkg::CFG_SIG1_CARE:   sig_mask[1] = data[mbss_pkg::MAX_SIG_BYTES-1:0];
            mbss_pkg::CFG_SIG1_LENGTH: sig_size[1] = data[mbss_pkg::LEN_W-1:0];
            mbss_pkg::CFG_REGION_BASE: base_addr   = data;
            default:                   ;
        endcase
    endtask

    // shift one byte into the window and queue the hits it completes, lowest index first
    task automatic scan_byte(input logic [mbss_pkg::BYTE_W-1:0] value, input logic new_region);
        logic [mbss_pkg::BYTE_W-1:0]   recent [mbss_pkg::MAX_SIG_BYTES];
        logic [mbss_pkg::ADDR_W-1:0]   start_addr [mbss_pkg::NUM_SIGS];
        logic [mbss_pkg::NUM_SIGS-1:0] matched;
        int                            len;
        hit_t                          h;
        if (new_region)
        begin
            region_count = '0;
        end
        if (region_count != '1)
        begin
            region_count++;
        end
        recent[0] = value;
        for (int i = 1; i < mbss_pkg::MAX_SIG_BYTES; i++)
        begin
            recent[i] = history[i-1];
        end
        for (int k = 0; k < mbss_pkg::NUM_SIGS; k++)
        begin
            len = (sig_size[k] > mbss_pkg::MAX_SIG_BYTES) ? mbss_pkg::MAX_SIG_BYTES
                                                           : int'(sig_size[k]);
            matched[k] = (len != 0) && (region_count >= mbss_pkg::ADDR_W'(len));
            for (int j = 0; j < len; j++)
            begin
                if (sig_mask[k][j] &&
                    recent[len-1-j] != sig_pat[k][mbss_pkg::BYTE_W*j +: mbss_pkg::BYTE_W])
                begin
                    matched[k] = 1'b0;
                end
            end
            start_addr[k] = base_addr + region_count - mbss_pkg::ADDR_W'(len);
        end
        for (int k = 0; k < mbss_pkg::NUM_SIGS; k++)
        begin
            if (matched[k])
            begin
                h.addr = start_addr[k];
                h.sig  = mbss_pkg::SIG_IDX_W'(k);
                h.last = ((matched >> (k + 1)) == '0);
                expected_hits.insert(expected_hits.size(), h);
            end
        end
        for (int i = mbss_pkg::MAX_SIG_BYTES - 2; i > 0; i--)
        begin
            history[i] = history[i-1];
        end
        history[0] = value;
    endtask

    task automatic check_hit();
        hit_t want;
        if (expected_hits.size() == 0)
        begin
            report($sformatf("hit %0d at %h sig %0d with no hit expected",
                             hits_seen, m_axis_tdata, m_axis_tuser));
        end
        else
        begin
            want = expected_hits.pop_front();
            if (m_axis_tdata !== want.addr)
            begin
                report($sformatf("hit %0d: address %h, expected %h",
                                 hits_seen, m_axis_tdata, want.addr));
            end
            if (m_axis_tuser !== want.sig)
            begin
                report($sformatf("hit %0d: signature %0d, expected %0d",
                                 hits_seen, m_axis_tuser, want.sig));
            end
            if (m_axis_tlast !== want.last)
            begin
                report($sformatf("hit %0d: run end %b, expected %b",
                                 hits_seen, m_axis_tlast, want.last));
            end
        end
        hits_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mbss_pkg::NUM_SIGS; k++)
            begin
                sig_pat[k]  = '0;
                sig_mask[k] = '0;
                sig_size[k] = '0;
            end
            for (int i = 0; i < mbss_pkg::MAX_SIG_BYTES - 1; i++)
            begin
                history[i] = '0;
            end
            base_addr    = '0;
            region_count = '0;
            expected_hits.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_hit();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_byte(s_axis_tdata, s_axis_tuser);
            end
        end
        hits_pending = expected_hits.size();
    end

endmodule

### tb/masked_byte_signature_scan_top_tb.sv
`timescale 1ns / 1ps
// masked_byte_signature_scan_top_tb: drives directed and random byte streams and register
// writes into the scanner and prints the verdict; mbss_hit_checker does the comparing
// uses mbss_pkg, masked_byte_signature_scan_top and mbss_hit_checker
module masked_byte_signature_scan_top_tb;

    localparam logic [mbss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int COPY_PHASE    = 2;
    localparam int GAPLESS_PHASE = 3;

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;
    logic                               s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [mbss_pkg::ADDR_W-1:0]        m_axis_tdata;
    logic [mbss_pkg::SIG_IDX_W-1:0]     m_axis_tuser;
    logic                               m_axis_tlast;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [mbss_pkg::ADDR_W-1:0]        cfg_data;
    logic                               gapless;
    int                                 mismatches;
    int                                 hits_pending;

    logic [mbss_pkg::MAX_SIG_BYTES*mbss_pkg::BYTE_W-1:0] sig_pat [mbss_pkg::NUM_SIGS];
    logic [mbss_pkg::MAX_SIG_BYTES-1:0]                  sig_mask [mbss_pkg::NUM_SIGS];
    logic [mbss_pkg::LEN_W-1:0]                          sig_size [mbss_pkg::NUM_SIGS];

    masked_byte_signature_scan_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mbss_hit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .hits_pending  (hits_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= gapless || ($urandom_range(99) >= 28);
    end

    function automatic logic [mbss_pkg::ADDR_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(input logic [mbss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbss_pkg::ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_signature(input int k,
                                  input logic [mbss_pkg::MAX_SIG_BYTES*mbss_pkg::BYTE_W-1:0] pat,
                                  input logic [mbss_pkg::MAX_SIG_BYTES-1:0] mask,
                                  input logic [mbss_pkg::LEN_W-1:0] size);
        write_reg((k == 0) ? mbss_pkg::CFG_SIG0_BYTES : mbss_pkg::CFG_SIG1_BYTES, pat);
        write_reg((k == 0) ? mbss_pkg::CFG_SIG0_CARE : mbss_pkg::CFG_SIG1_CARE,
                  mbss_pkg::ADDR_W'(mask));
        write_reg((k == 0) ? mbss_pkg::CFG_SIG0_LENGTH : mbss_pkg::CFG_SIG1_LENGTH,
                  mbss_pkg::ADDR_W'(size));
        sig_pat[k]  = pat;
        sig_mask[k] = mask;
        sig_size[k] = size;
    endtask

    // lengths favor 1..8 with some oversized ones; care and pattern often at their extremes
    task automatic randomize_signature(input int k, input logic may_disable);
        logic [mbss_pkg::MAX_SIG_BYTES*mbss_pkg::BYTE_W-1:0] pat;
        logic [mbss_pkg::MAX_SIG_BYTES-1:0]                  mask;
        logic [mbss_pkg::LEN_W-1:0]                          size;
        case ($urandom_range(9))
            0:       size = may_disable ? '0 : mbss_pkg::LEN_W'(mbss_pkg::MAX_SIG_BYTES);
            1:       size = mbss_pkg::LEN_W'($urandom_range(15, 9));
            2:       size = mbss_pkg::LEN_W'(mbss_pkg::MAX_SIG_BYTES);
            default: size = mbss_pkg::LEN_W'($urandom_range(mbss_pkg::MAX_SIG_BYTES, 1));
        endcase
        case ($urandom_range(5))
            0:       mask = '0;
            1:       mask = '1;
            default: mask = mbss_pkg::MAX_SIG_BYTES'($urandom);
        endcase
        case ($urandom_range(5))
            0:       pat = '0;
            1:       pat = '1;
            default: pat = rand_word();
        endcase
        load_signature(k, pat, mask, size);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic new_region);
        while (!gapless && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= new_region;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // stop the stream, let every expected hit arrive and the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (hits_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int sent;
        int r;
        int k;
        int keep;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        gapless       = 1'b0;
        for (int i = 0; i < mbss_pkg::NUM_SIGS; i++)
        begin
            sig_pat[i]  = '0;
            sig_mask[i] = '0;
            sig_size[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both signatures disabled out of reset
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain();

        // sig1 oversized and partly masked, both end on the same byte; base wraps
        write_reg(CFG_UNUSED, rand_word());
        load_signature(0, 64'h0000_0000_EFBE_ADDE, 8'hFF, 4'd4);
        load_signature(1, 64'hEFBE_ADDE_0000_0000, 8'hF0, 4'hF);
        write_reg(mbss_pkg::CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hDE, 1'b1);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        // a region start in the middle of the signature hides the earlier bytes
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hEF, 1'b0);
        drain();

        // sig0 off, sig1 one byte with no care bits hits on every byte
        load_signature(0, 64'h0000_0000_EFBE_ADDE, 8'hFF, 4'd0);
        load_signature(1, rand_word(), 8'h00, 4'd1);
        write_reg(mbss_pkg::CFG_REGION_BASE, '0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_signature(0, 1'b0);
            if (p == COPY_PHASE)
            begin
                load_signature(1, sig_pat[0], sig_mask[0], sig_size[0]);
            end
            else
            begin
                randomize_signature(1, 1'b1);
            end
            case ($urandom_range(3))
                0:       write_reg(mbss_pkg::CFG_REGION_BASE, '0);
                1:       write_reg(mbss_pkg::CFG_REGION_BASE, '1);
                2:       write_reg(mbss_pkg::CFG_REGION_BASE,
                                   ~mbss_pkg::ADDR_W'($urandom_range(40)));
                default: write_reg(mbss_pkg::CFG_REGION_BASE, rand_word());
            endcase
            gapless <= (p == GAPLESS_PHASE);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    k = (sig_size[1] != '0 && $urandom_range(1) == 1) ? 1 : 0;
                    keep = (sig_size[k] > mbss_pkg::MAX_SIG_BYTES) ? mbss_pkg::MAX_SIG_BYTES
                                                                    : int'(sig_size[k]);
                    // a few sequences are cut short
                    if (r < 8)
                    begin
                        keep = $urandom_range(keep - 1);
                    end
                    for (int j = 0; j < keep; j++)
                    begin
                        send_byte(sig_mask[k][j]
                                      ? sig_pat[k][mbss_pkg::BYTE_W*j +: mbss_pkg::BYTE_W]
                                      : mbss_pkg::BYTE_W'($urandom),
                                  $urandom_range(99) < 4);
                    end
                    sent += keep;
                end
                else
                begin
                    send_byte(mbss_pkg::BYTE_W'($urandom), $urandom_range(99) < 4);
                    sent++;
                end
            end
            drain();
            gapless <= 1'b0;
        end

        if (mismatches == 0 && hits_pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
